/* rtl/vdp_lt_pkg.sv */
// Shared types, constants and decode functions for the VDP port and line timing unit.
`timescale 1ns / 1ps

package vdp_lt_pkg;

  // Default store depths; both must be powers of two.
  localparam int unsigned VramDepthDefault = 16384;
  localparam int unsigned CramDepthDefault = 32;

  // Timing constants in machine cycles.
  localparam logic [15:0] FRAME_CYCLES = 16'd59719;
  localparam logic [8:0]  LINE_CYCLES  = 9'd228;

  // Active heights of the display modes.
  localparam logic [8:0] HEIGHT_192 = 9'd192;
  localparam logic [8:0] HEIGHT_224 = 9'd224;
  localparam logic [8:0] HEIGHT_240 = 9'd240;

  // Line at which the V counter jumps back in the 192-line mode.
  localparam logic [8:0] VCOUNT_JUMP = 9'h0DB;
  localparam logic [8:0] VCOUNT_BACK = 9'd6;

  // H counter is floor(line_cycles * 255 / 228). The product below with a
  // 25-bit shift gives the exact quotient for every 9-bit cycle count.
  localparam logic [25:0] HCOUNT_MUL   = 26'd37528095;
  localparam int unsigned HCOUNT_SHIFT = 25;

  localparam logic [13:0] VRAM_ADDR_MAX = 14'h3FFF;
  localparam logic [13:0] CRAM_ADDR_MAX = 14'h001F;

  localparam int unsigned NumRegs     = 16;
  localparam logic [3:0]  ModeReg0    = 4'd0;
  localparam logic [3:0]  ModeReg1    = 4'd1;
  localparam logic [3:0]  LineIrqReg  = 4'd10;

  localparam logic [7:0] REG_RESET [NumRegs] = '{
    8'h36, 8'h80, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFB, 8'h00,
    8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  typedef enum logic [2:0] {
    OpCtrlWr   = 3'd0,
    OpDataWr   = 3'd1,
    OpStatusRd = 3'd2,
    OpDataRd   = 3'd3,
    OpVRd      = 3'd4,
    OpHRd      = 3'd5,
    OpTick     = 3'd6,
    OpIrqPoll  = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ModeOther = 2'd0,
    Mode192   = 2'd1,
    Mode224   = 2'd2,
    Mode240   = 2'd3
  } mode_e;

  // Second control byte, top two bits.
  typedef enum logic [1:0] {
    CtlVramLo = 2'd0,
    CtlVramHi = 2'd1,
    CtlRegWr  = 2'd2,
    CtlCram   = 2'd3
  } ctl_e;

  // One result on its way to the output.
  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_taken;
    logic       irq_level;
    logic       vram_rd;
    logic       cram_rd;
  } res_t;

  function automatic mode_e decode_mode(input logic [7:0] r0, input logic [7:0] r1);
    logic [3:0] idx;
    mode_e      m;
    idx = {r0[2], r1[3], r0[1], r1[4]};
    case (idx)
      4'd8, 4'd10, 4'd12, 4'd15: m = Mode192;
      4'd11:                     m = Mode224;
      4'd14:                     m = Mode240;
      default:                   m = ModeOther;
    endcase
    return m;
  endfunction

  function automatic logic [8:0] active_height(input mode_e m);
    logic [8:0] h;
    case (m)
      Mode240: h = HEIGHT_240;
      Mode224: h = HEIGHT_224;
      default: h = HEIGHT_192;
    endcase
    return h;
  endfunction

endpackage

/* rtl/vdp_lt_ram.sv */
// Generic single-port synchronous RAM with a registered read.
`timescale 1ns / 1ps

module vdp_lt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/vdp_port_and_line_timing_unit.sv */
// Top level of the VDP control/data port with line and frame timing.
`timescale 1ns / 1ps
//
//  Channel   Direction  Width  Contents
//  s_axis    in         24     [2:0] operation, [10:3] data_byte, [18:11] tick_cycles
//  m_axis    out        16     [7:0] read_data, [8] irq_taken, [9] irq_level
//
// Every accepted transaction produces exactly one result transaction. It
// passes the first result stage, which waits for the synchronous RAM read,
// and then the output register. One transaction is taken per clock while
// the output keeps flowing; the limit is the single RAM port, which serves
// one access per transaction.
// After reset the video RAM and color RAM are swept to zero, one entry per
// cycle; s_axis_tready_o stays low meanwhile.
// When the output stalls, the pending result and the output register hold
// two results before s_axis_tready_o drops.

module vdp_port_and_line_timing_unit #(
  parameter int unsigned VRAM_DEPTH = vdp_lt_pkg::VramDepthDefault,
  parameter int unsigned CRAM_DEPTH = vdp_lt_pkg::CramDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [2:0] operation, [10:3] data_byte, [18:11] tick_cycles, [23:19] zero
  input  logic [23:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] read_data, [8] irq_taken, [9] irq_level, [15:10] zero
  output logic [15:0] m_axis_tdata_o
);

  // Index widths of the two stores. Depths are powers of two, so the
  // address reduction below is a plain mask.
  localparam int unsigned VaW = $clog2(VRAM_DEPTH);
  localparam int unsigned CaW = $clog2(CRAM_DEPTH);

  // Input fields.
  vdp_lt_pkg::op_e operation;
  logic [7:0]      data_byte;
  logic [7:0]      tick_cycles;

  // Port and timing state, all in flip-flops.
  logic [13:0]       addr_q, addr_d;
  logic              to_vram_q, to_vram_d;
  logic              second_q, second_d;
  logic [7:0]        latch_q, latch_d;
  logic [8:0]        line_q, line_d;
  logic [15:0]       frame_q, frame_d;
  logic [8:0]        lcyc_q, lcyc_d;
  logic              vblank_q, vblank_d;
  logic signed [9:0] lirq_q, lirq_d;
  logic              pvbl_q, pvbl_d;
  logic              pline_q, pline_d;
  logic [7:0]        regs_q [vdp_lt_pkg::NumRegs];
  logic              reg_we;
  logic [3:0]        reg_idx;
  logic [7:0]        reg0_after;
  logic [7:0]        reg1_after;

  vdp_lt_pkg::mode_e mode;

  // Clearing sweep over both RAMs after reset.
  logic           clr_q;
  logic [VaW-1:0] clr_cnt_q;

  // Result pipeline: one stage waiting for the RAM read, then the output.
  logic                  s1_v_q;
  vdp_lt_pkg::res_t      s1_q, s1_d;
  logic                  out_v_q;
  logic [7:0]            out_rd_q;
  logic                  out_taken_q;
  logic                  out_level_q;
  logic                  adv;
  logic                  accept;

  // RAM ports.
  logic           vram_we, vram_re;
  logic [VaW-1:0] vram_addr;
  logic [7:0]     vram_wdata, vram_rdata;
  logic           cram_we, cram_re;
  logic [CaW-1:0] cram_addr;
  logic [7:0]     cram_wdata, cram_rdata;
  logic [VaW-1:0] vram_idx;
  logic [CaW-1:0] cram_idx;

  // Tick arithmetic.
  logic [16:0]       fsum;
  logic              frame_wrap;
  logic [8:0]        lc_base;
  logic [8:0]        ln_base;
  logic signed [9:0] cnt_base;
  logic [9:0]        lsum;
  logic [8:0]        lsum9;
  logic [8:0]        height;
  logic signed [9:0] cnt_next;

  // Counter reads.
  logic [34:0] h_prod;
  logic [8:0]  v_sub;

  assign operation   = vdp_lt_pkg::op_e'(s_axis_tdata_i[2:0]);
  assign data_byte   = s_axis_tdata_i[10:3];
  assign tick_cycles = s_axis_tdata_i[18:11];

  // Display mode only changes with registers 0 and 1, so it is decoded from
  // them directly.
  assign mode = vdp_lt_pkg::decode_mode(regs_q[vdp_lt_pkg::ModeReg0],
                                        regs_q[vdp_lt_pkg::ModeReg1]);

  assign adv             = !s1_v_q || !out_v_q || m_axis_tready_i;
  assign s_axis_tready_o = !clr_q && adv;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign vram_idx = VaW'(32'(addr_q) % VRAM_DEPTH);
  assign cram_idx = CaW'(32'(addr_q[4:0]) % CRAM_DEPTH);

  // H counter: exact constant-reciprocal division of line_cycles*255 by 228.
  assign h_prod = 35'(lcyc_q) * 35'(vdp_lt_pkg::HCOUNT_MUL);
  assign v_sub  = line_q - vdp_lt_pkg::VCOUNT_BACK;

  // Main update for one transaction. Everything except the RAM contents is
  // computed here in the cycle of acceptance.
  always_comb begin
    addr_d    = addr_q;
    to_vram_d = to_vram_q;
    second_d  = second_q;
    latch_d   = latch_q;
    line_d    = line_q;
    frame_d   = frame_q;
    lcyc_d    = lcyc_q;
    vblank_d  = vblank_q;
    lirq_d    = lirq_q;
    pvbl_d    = pvbl_q;
    pline_d   = pline_q;
    reg_we    = 1'b0;
    reg_idx   = data_byte[3:0];
    s1_d      = '0;
    vram_re   = 1'b0;
    cram_re   = 1'b0;

    fsum       = 17'(frame_q) + 17'(tick_cycles);
    frame_wrap = fsum > 17'(vdp_lt_pkg::FRAME_CYCLES);
    lc_base    = frame_wrap ? 9'd0 : lcyc_q;
    ln_base    = frame_wrap ? 9'd0 : line_q;
    cnt_base   = frame_wrap ? $signed({2'b00, regs_q[vdp_lt_pkg::LineIrqReg]}) : lirq_q;
    lsum       = 10'(lc_base) + 10'(tick_cycles);
    lsum9      = lsum[8:0];
    height     = vdp_lt_pkg::active_height(mode);
    cnt_next   = cnt_base;

    case (operation)
      vdp_lt_pkg::OpCtrlWr: begin
        if (second_q) begin
          case (vdp_lt_pkg::ctl_e'(data_byte[7:6]))
            vdp_lt_pkg::CtlVramLo, vdp_lt_pkg::CtlVramHi: begin
              addr_d    = {data_byte[5:0], latch_q};
              to_vram_d = 1'b1;
            end
            vdp_lt_pkg::CtlRegWr: begin
              reg_we = 1'b1;
            end
            default: begin
              addr_d    = {9'd0, latch_q[4:0]};
              to_vram_d = 1'b0;
            end
          endcase
          second_d = 1'b0;
        end else begin
          second_d = 1'b1;
        end
        latch_d = data_byte;
      end
      vdp_lt_pkg::OpDataWr: begin
        second_d = 1'b0;
        if (to_vram_q) begin
          addr_d = (addr_q + 14'd1) & vdp_lt_pkg::VRAM_ADDR_MAX;
        end else begin
          addr_d = (addr_q + 14'd1) & vdp_lt_pkg::CRAM_ADDR_MAX;
        end
      end
      vdp_lt_pkg::OpStatusRd: begin
        s1_d.read_data = {vblank_q, 7'd0};
        vblank_d = 1'b0;
        pvbl_d   = 1'b0;
        pline_d  = 1'b0;
        second_d = 1'b0;
      end
      vdp_lt_pkg::OpDataRd: begin
        second_d = 1'b0;
        if (to_vram_q) begin
          vram_re      = 1'b1;
          s1_d.vram_rd = 1'b1;
          if (addr_q < vdp_lt_pkg::VRAM_ADDR_MAX) begin
            addr_d = addr_q + 14'd1;
          end
        end else begin
          cram_re      = 1'b1;
          s1_d.cram_rd = 1'b1;
          if (addr_q < vdp_lt_pkg::CRAM_ADDR_MAX) begin
            addr_d = addr_q + 14'd1;
          end
        end
      end
      vdp_lt_pkg::OpVRd: begin
        if (mode == vdp_lt_pkg::Mode192 && line_q >= vdp_lt_pkg::VCOUNT_JUMP) begin
          s1_d.read_data = v_sub[7:0];
        end else begin
          s1_d.read_data = line_q[7:0];
        end
      end
      vdp_lt_pkg::OpHRd: begin
        s1_d.read_data = h_prod[vdp_lt_pkg::HCOUNT_SHIFT +: 8];
      end
      vdp_lt_pkg::OpTick: begin
        // A frame boundary restarts the line timing before the line check.
        frame_d = frame_wrap ? 16'(fsum - 17'(vdp_lt_pkg::FRAME_CYCLES)) : fsum[15:0];
        lcyc_d  = lsum9;
        line_d  = ln_base;
        lirq_d  = cnt_base;
        if (lsum9 > vdp_lt_pkg::LINE_CYCLES) begin
          lcyc_d = lsum9 - vdp_lt_pkg::LINE_CYCLES;
          if (ln_base < height) begin
            cnt_next = cnt_base - 10'sd1;
          end else if (ln_base == height) begin
            vblank_d = 1'b1;
            pvbl_d   = 1'b1;
            cnt_next = cnt_base - 10'sd1;
          end
          if (cnt_next < 0) begin
            pline_d = 1'b1;
            lirq_d  = $signed({2'b00, regs_q[vdp_lt_pkg::LineIrqReg]});
          end else begin
            lirq_d  = cnt_next;
          end
          line_d = ln_base + 9'd1;
        end
      end
      default: begin
        // Interrupt poll: the frame interrupt has priority over the line one.
        if (pvbl_q && regs_q[vdp_lt_pkg::ModeReg1][5]) begin
          pvbl_d         = 1'b0;
          s1_d.irq_taken = 1'b1;
        end else if (pline_q && regs_q[vdp_lt_pkg::ModeReg0][4]) begin
          pline_d        = 1'b0;
          s1_d.irq_taken = 1'b1;
        end
      end
    endcase

    // Interrupt level after the update. A register write in this transaction
    // can change either enable bit, so the written value is used at once.
    reg0_after = (reg_we && reg_idx == vdp_lt_pkg::ModeReg0) ?
                 latch_q : regs_q[vdp_lt_pkg::ModeReg0];
    reg1_after = (reg_we && reg_idx == vdp_lt_pkg::ModeReg1) ?
                 latch_q : regs_q[vdp_lt_pkg::ModeReg1];
    s1_d.irq_level = (pvbl_d && reg1_after[5]) || (pline_d && reg0_after[4]);
  end

  // RAM port selection: the clearing sweep owns both ports after reset.
  always_comb begin
    if (clr_q) begin
      vram_we    = 1'b1;
      vram_addr  = clr_cnt_q;
      vram_wdata = 8'd0;
      cram_we    = 1'b1;
      cram_addr  = clr_cnt_q[CaW-1:0];
      cram_wdata = 8'd0;
    end else begin
      vram_we    = accept && operation == vdp_lt_pkg::OpDataWr && to_vram_q;
      vram_addr  = vram_idx;
      vram_wdata = data_byte;
      cram_we    = accept && operation == vdp_lt_pkg::OpDataWr && !to_vram_q;
      cram_addr  = cram_idx;
      cram_wdata = data_byte;
    end
  end

  vdp_lt_ram #(
    .Width (8),
    .Depth (VRAM_DEPTH)
  ) u_vram (
    .clk_i   (clk_i),
    .we_i    (vram_we),
    .re_i    (accept && vram_re),
    .addr_i  (vram_addr),
    .wdata_i (vram_wdata),
    .rdata_o (vram_rdata)
  );

  vdp_lt_ram #(
    .Width (8),
    .Depth (CRAM_DEPTH)
  ) u_cram (
    .clk_i   (clk_i),
    .we_i    (cram_we),
    .re_i    (accept && cram_re),
    .addr_i  (cram_addr),
    .wdata_i (cram_wdata),
    .rdata_o (cram_rdata)
  );

  // Port and timing state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q    <= '0;
      to_vram_q <= 1'b1;
      second_q  <= 1'b0;
      latch_q   <= '0;
      line_q    <= '0;
      frame_q   <= '0;
      lcyc_q    <= '0;
      vblank_q  <= 1'b0;
      lirq_q    <= 10'sd255;
      pvbl_q    <= 1'b0;
      pline_q   <= 1'b0;
      for (int i = 0; i < vdp_lt_pkg::NumRegs; i++) begin
        regs_q[i] <= vdp_lt_pkg::REG_RESET[i];
      end
    end else if (accept) begin
      addr_q    <= addr_d;
      to_vram_q <= to_vram_d;
      second_q  <= second_d;
      latch_q   <= latch_d;
      line_q    <= line_d;
      frame_q   <= frame_d;
      lcyc_q    <= lcyc_d;
      vblank_q  <= vblank_d;
      lirq_q    <= lirq_d;
      pvbl_q    <= pvbl_d;
      pline_q   <= pline_d;
      if (reg_we) begin
        regs_q[reg_idx] <= latch_q;
      end
    end
  end

  // Clearing sweep, one entry of each RAM per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + VaW'(1);
      if (clr_cnt_q == VaW'(VRAM_DEPTH - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  // Result pipeline. The RAM read data stays put while the first stage
  // waits, because no new read is issued without an accepted transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (adv) begin
        s1_v_q <= accept;
      end
      if (!out_v_q || m_axis_tready_i) begin
        out_v_q <= s1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
    if (s1_v_q && (!out_v_q || m_axis_tready_i)) begin
      if (s1_q.vram_rd) begin
        out_rd_q <= vram_rdata;
      end else if (s1_q.cram_rd) begin
        out_rd_q <= cram_rdata;
      end else begin
        out_rd_q <= s1_q.read_data;
      end
      out_taken_q <= s1_q.irq_taken;
      out_level_q <= s1_q.irq_level;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {6'd0, out_level_q, out_taken_q, out_rd_q};

endmodule
